>>> src/fsq_pkg.sv
// Shared types, constants and codes of the sign and square-root unit.
package fsq_pkg;

	localparam int unsigned WordW = 32;
	localparam int unsigned FuncW = 2;
	localparam int unsigned MantW = 24;
	localparam int unsigned RootW = 27;
	localparam int unsigned RadW  = 2 * RootW;
	localparam int unsigned RemW  = RootW + 2;
	localparam int unsigned QueueDepthDefault = 4;

	localparam logic [FuncW-1:0] FUNC_ABS  = 2'd0;
	localparam logic [FuncW-1:0] FUNC_NEG  = 2'd1;
	localparam logic [FuncW-1:0] FUNC_SQRT = 2'd2;

	localparam logic [WordW-1:0] SIGN_MASK = 32'h8000_0000;
	localparam logic [WordW-1:0] MAG_MASK  = 32'h7FFF_FFFF;
	localparam logic [WordW-1:0] INF_BITS  = 32'h7F80_0000;
	localparam logic [WordW-1:0] QNAN_BITS = 32'h7FC0_0000;

	// Classified item passed from the front part to the back part.
	typedef struct packed {
		logic             fault;
		logic             do_root;
		logic [WordW-1:0] word;
		logic             wr;
		logic             inv;
		logic             clr;
		logic [MantW:0]   mant;
		logic signed [9:0] bexp;
	} fsq_item_t;

	typedef struct packed {
		logic [WordW-1:0] result;
		logic             wr;
		logic             fault;
		logic             inv;
		logic             clr;
	} fsq_res_t;

endpackage

>>> src/fsq_front.sv
// Front part: takes instructions, classifies them and normalises the mantissa.
module fsq_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic [fsq_pkg::FuncW-1:0]   func,
	input  logic [fsq_pkg::WordW-1:0]   operand,
	input  logic                        usable,
	output logic                        item_valid,
	output fsq_pkg::fsq_item_t          item
);
	import fsq_pkg::*;

	logic [22:0] frac;
	logic [7:0]  ex;
	logic [4:0]  lz;
	logic [MantW-1:0] norm;
	logic signed [9:0] e_n;
	logic signed [9:0] p;
	fsq_item_t   nxt;

	assign frac = operand[22:0];
	assign ex   = operand[30:23];

	// Leading-zero count for subnormal inputs.
	always_comb begin
		lz = 5'd0;
		for (int i = 0; i < 23; i++) begin
			if (frac[i]) lz = 5'(22 - i);
		end
	end

	always_comb begin
		nxt = '0;
		if (ex == 8'd0) begin
			norm = MantW'({1'b0, frac} << (lz + 5'd1));
			e_n  = 10'sd0 - $signed({5'd0, lz});
		end else begin
			norm = {1'b1, frac};
			e_n  = $signed({2'd0, ex});
		end
		p = e_n - 10'sd150;
		nxt.fault = !usable;
		if (usable) begin
			case (func)
				FUNC_ABS: begin
					nxt.word = operand & MAG_MASK;
					nxt.wr = 1'b1;
					nxt.clr = 1'b1;
				end
				FUNC_NEG: begin
					nxt.word = operand ^ SIGN_MASK;
					nxt.wr = 1'b1;
					nxt.clr = 1'b1;
				end
				FUNC_SQRT: begin
					nxt.wr = 1'b1;
					if ((operand & MAG_MASK) > INF_BITS) begin
						nxt.word = QNAN_BITS;
					end else if ((operand & MAG_MASK) == '0) begin
						nxt.word = operand & SIGN_MASK;
					end else begin
						nxt.inv = operand[31];
						if ((operand & MAG_MASK) == INF_BITS) begin
							nxt.word = INF_BITS;
						end else begin
							nxt.do_root = 1'b1;
							nxt.mant = p[0] ? {norm, 1'b0} : {1'b0, norm};
							// Halved even exponent plus the fixed bias terms.
							nxt.bexp = ((p[0] ? p - 10'sd1 : p) - 10'sd28) >>> 1;
						end
					end
				end
				default: nxt.wr = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
		end else begin
			item_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid) item <= nxt;
	end

endmodule

>>> src/fsq_queue.sv
// Short queue between the front and back parts.
module fsq_queue #(
	parameter int unsigned Depth = fsq_pkg::QueueDepthDefault
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_en,
	input  fsq_pkg::fsq_item_t wr_item,
	output logic               full,
	input  logic               rd_en,
	output logic               rd_valid,
	output fsq_pkg::fsq_item_t rd_item
);
	import fsq_pkg::*;

	localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

	fsq_item_t        mem_q [Depth];
	logic [AW-1:0]    wp_q, rp_q;
	logic [AW:0]      cnt_q;

	assign full     = (cnt_q == (AW+1)'(Depth));
	assign rd_valid = (cnt_q != '0);
	assign rd_item  = mem_q[rp_q];

	function automatic logic [AW-1:0] inc(input logic [AW-1:0] v);
		return (v == AW'(Depth - 1)) ? '0 : v + AW'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wp_q] <= wr_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr_en) wp_q <= inc(wp_q);
			if (rd_en) rp_q <= inc(rp_q);
			cnt_q <= cnt_q + (AW+1)'(wr_en) - (AW+1)'(rd_en);
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) !(wr_en && full))
		else $error("queue written while full");
	assert property (@(posedge clk) disable iff (!arst_n) rd_en |-> rd_valid)
		else $error("queue read while empty");
	assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && !rd_en) |=> cnt_q == $past(cnt_q) + 1'b1)
		else $error("queue count did not rise");

endmodule

>>> src/fsq_back.sv
// Back part: pipelined restoring square root, one result bit per stage, then rounding.
module fsq_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  fsq_pkg::fsq_item_t in_item,
	output logic               out_valid,
	output fsq_pkg::fsq_res_t  out_res
);
	import fsq_pkg::*;

	// Radicand m << 28 holds 53 bits; the root has 27 bits.
	logic               v_s   [1:RootW];
	fsq_item_t          it_s  [1:RootW];
	logic [RadW-1:0]    rad_s [1:RootW];
	logic [RemW-1:0]    rem_s [1:RootW];
	logic [RootW-1:0]   root_s[1:RootW];

	for (genvar k = 0; k < RootW; k++) begin : g_stage
		logic             v_in;
		fsq_item_t        it_in;
		logic [RadW-1:0]  rad_in;
		logic [RemW-1:0]  rem_in;
		logic [RootW-1:0] root_in;
		logic [RemW-1:0]  trial, cand;
		logic             ok;
		if (k == 0) begin : g_first
			// The first stage takes its item straight from the queue.
			assign v_in    = in_valid;
			assign it_in   = in_item;
			assign rad_in  = RadW'({in_item.mant, 28'd0});
			assign rem_in  = '0;
			assign root_in = '0;
		end else begin : g_next
			assign v_in    = v_s[k];
			assign it_in   = it_s[k];
			assign rad_in  = rad_s[k];
			assign rem_in  = rem_s[k];
			assign root_in = root_s[k];
		end
		always_comb begin
			trial = {rem_in[RemW-3:0], rad_in[RadW-1 -: 2]};
			cand  = {root_in, 2'b01};
			ok    = (trial >= cand);
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_s[k+1] <= 1'b0;
			else v_s[k+1] <= v_in;
		end
		always_ff @(posedge clk) begin
			it_s[k+1]   <= it_in;
			rad_s[k+1]  <= rad_in << 2;
			rem_s[k+1]  <= ok ? trial - cand : trial;
			root_s[k+1] <= {root_in[RootW-2:0], ok};
		end
	end

	logic [RootW-1:0] r;
	logic             big, guard, sticky;
	logic [MantW:0]   q;
	logic signed [9:0] be;
	fsq_res_t         nxt;

	always_comb begin
		r   = root_s[RootW];
		big = r[26];
		if (big) begin
			q = {1'b0, r[26:3]};
			guard = r[2];
			sticky = (r[1:0] != '0) || (rem_s[RootW] != '0);
		end else begin
			q = {1'b0, r[25:2]};
			guard = r[1];
			sticky = r[0] || (rem_s[RootW] != '0);
		end
		be = it_s[RootW].bexp + (big ? 10'sd153 : 10'sd152);
		if (guard && (sticky || q[0])) q = q + 1'b1;
		if (q[MantW]) begin
			q = q >> 1;
			be = be + 10'sd1;
		end
		nxt.wr = it_s[RootW].wr;
		nxt.fault = it_s[RootW].fault;
		nxt.inv = it_s[RootW].inv;
		nxt.clr = it_s[RootW].clr;
		nxt.result = it_s[RootW].do_root ? {1'b0, be[7:0], q[22:0]} : it_s[RootW].word;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else out_valid <= v_s[RootW];
	end

	always_ff @(posedge clk) begin
		out_res <= nxt;
	end

endmodule

>>> src/fp_sign_and_sqrt_unit.sv
// Top level of the single-precision sign and square-root unit.
//
//  channel  | signals                                       | transfer
//  ---------+-----------------------------------------------+-------------------------
//  command  | start, busy, func, operand                    | start high, busy low
//  result   | done, result, write_dest, unusable_fault, ... | done high, one cycle
//  config   | cfg_valid, cfg_ready, cfg_data                | cfg_valid and cfg_ready
//
// A command may be given in every cycle while busy is low. Its result passes
// through the front classifier register, the queue, 27 square-root stages (one
// root bit each) and the rounding output register. Every command, ABS and NEG
// included, flows through the same stages, so results keep their order. Busy only
// rises if the queue fills, which the never-stalling back part prevents in practice.
// Reset restores the unit to usable and empties every stage.
module fp_sign_and_sqrt_unit #(
	parameter int unsigned QueueDepth = fsq_pkg::QueueDepthDefault
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [fsq_pkg::FuncW-1:0]   func,
	input  logic [fsq_pkg::WordW-1:0]   operand,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic                        cfg_data,
	output logic                        done,
	output logic [fsq_pkg::WordW-1:0]   result,
	output logic                        write_dest,
	output logic                        unusable_fault,
	output logic                        set_invalid,
	output logic                        clear_over_under
);
	import fsq_pkg::*;

	logic       usable_q;
	logic       fr_valid, q_full, q_valid;
	fsq_item_t  fr_item, q_item;
	fsq_res_t   res;

	// The unit-usable register; writes are always taken.
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) usable_q <= 1'b1;
		else if (cfg_valid) usable_q <= cfg_data;
	end

	// Hold commands off while the queue is full so no classified item is lost.
	assign busy = q_full;

	fsq_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(start && !busy), .func(func),
		.operand(operand), .usable(usable_q), .item_valid(fr_valid), .item(fr_item)
	);

	// The back part never stalls, so the queue drains every cycle it holds data.
	fsq_queue #(.Depth(QueueDepth)) u_queue (
		.clk(clk), .arst_n(arst_n), .wr_en(fr_valid), .wr_item(fr_item), .full(q_full),
		.rd_en(q_valid), .rd_valid(q_valid), .rd_item(q_item)
	);

	fsq_back u_back (
		.clk(clk), .arst_n(arst_n), .in_valid(q_valid), .in_item(q_item),
		.out_valid(done), .out_res(res)
	);

	assign result           = res.result;
	assign write_dest       = res.wr;
	assign unusable_fault   = res.fault;
	assign set_invalid      = res.inv;
	assign clear_over_under = res.clr;

	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(write_dest && unusable_fault))
		else $error("faulted result also writes");
	assert property (@(posedge clk) disable iff (!arst_n)
		(done && clear_over_under) |-> !set_invalid)
		else $error("sign operation flagged invalid");
	assert property (@(posedge clk) disable iff (!arst_n) !(fr_valid && q_full))
		else $error("front item dropped");

endmodule
